// ----- design/arrt_pkg.sv -----
// Shared types and constants for the address range region table.
package arrt_pkg;

  localparam int ID_W     = 10;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_FIND_ADDR  = 3'd3,
    CMD_FIND_ID    = 3'd4,
    CMD_CHECK_FREE = 3'd5,
    CMD_FIND_RANGE = 3'd6
  } cmd_t;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_FIRST_ID,
    PICK_POS
  } cell_pick_t;

  typedef struct packed {
    cell_op_t   op;
    cell_pick_t pick;
  } cell_ctl_t;

endpackage

// ----- design/arrt_cell.sv -----
// One table slot: holds an entry, shifts with its neighbors, compares against the keys.
module arrt_cell #(
  parameter int ADDR_BITS = 32,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                      clk,
  input  arrt_pkg::cell_ctl_t       ctl,
  input  logic [CNT_W-1:0]          count,
  input  logic [CNT_W-1:0]          pos,
  input  logic [arrt_pkg::ID_W-1:0] key_id,
  input  logic [ADDR_BITS-1:0]      key_a,
  input  logic [ADDR_BITS-1:0]      key_e,
  input  logic [ADDR_BITS-1:0]      key_len,
  input  logic                      left_stay,
  input  logic [arrt_pkg::ID_W-1:0] left_id,
  input  logic [ADDR_BITS-1:0]      left_base,
  input  logic [ADDR_BITS-1:0]      left_len,
  input  logic [arrt_pkg::ID_W-1:0] right_id,
  input  logic [ADDR_BITS-1:0]      right_base,
  input  logic [ADDR_BITS-1:0]      right_len,
  input  logic                      seen_in,
  output logic                      stay,
  output logic                      seen_out,
  output logic [arrt_pkg::ID_W-1:0] id,
  output logic [ADDR_BITS-1:0]      base,
  output logic [ADDR_BITS-1:0]      len,
  output logic                      holds_a,
  output logic                      le_a,
  output logic                      holds_e,
  output logic                      le_e,
  output logic [arrt_pkg::ID_W-1:0] pick_id,
  output logic [ADDR_BITS-1:0]      pick_base,
  output logic [ADDR_BITS-1:0]      pick_len
);
  import arrt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [ID_W-1:0]      id_r, id_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] len_r, len_nxt;
  logic                 holds_a_r, le_a_r, holds_e_r, le_e_r;
  logic                 valid, match, sel;
  logic                 cmp_le_a, cmp_le_e;
  logic [ADDR_BITS-1:0] end_sum;

  assign valid    = MY_IDX < count;
  assign match    = valid && (id_r == key_id);
  assign seen_out = seen_in | match;
  assign end_sum  = base_r + len_r;
  assign cmp_le_a = base_r <= key_a;
  assign cmp_le_e = base_r <= key_e;
  assign stay     = valid && cmp_le_a;

  always_comb begin
    id_nxt   = id_r;
    base_nxt = base_r;
    len_nxt  = len_r;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (!stay) begin
          if (left_stay) begin
            id_nxt   = key_id;
            base_nxt = key_a;
            len_nxt  = key_len;
          end else begin
            id_nxt   = left_id;
            base_nxt = left_base;
            len_nxt  = left_len;
          end
        end
      end
      CELL_REMOVE: begin
        if (seen_out) begin
          id_nxt   = right_id;
          base_nxt = right_base;
          len_nxt  = right_len;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (ctl.pick)
      PICK_FIRST_ID: sel = match && !seen_in;
      PICK_POS:      sel = (MY_IDX == pos);
      default:       sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    base_r    <= base_nxt;
    len_r     <= len_nxt;
    le_a_r    <= cmp_le_a;
    le_e_r    <= cmp_le_e;
    holds_a_r <= cmp_le_a && (end_sum > key_a);
    holds_e_r <= cmp_le_e && (end_sum > key_e);
  end

  assign id        = id_r;
  assign base      = base_r;
  assign len       = len_r;
  assign holds_a   = holds_a_r;
  assign le_a      = le_a_r;
  assign holds_e   = holds_e_r;
  assign le_e      = le_e_r;
  assign pick_id   = sel ? id_r : '0;
  assign pick_base = sel ? base_r : '0;
  assign pick_len  = sel ? len_r : '0;

endmodule

// ----- design/arrt_search.sv -----
// Binary search over the per-slot flags, one probe per cycle.
module arrt_search #(
  parameter int N     = 64,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic [N-1:0]     holds,
  input  logic [N-1:0]     le,
  output logic             busy,
  output logic             hit,
  output logic [CNT_W-1:0] pos
);
  logic             busy_r, busy_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] mid;
  logic [IDX_W-1:0] mid_idx;

  assign sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = sum[CNT_W:1];
  assign mid_idx = mid[IDX_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    hit_nxt  = hit_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    pos_nxt  = pos_r;
    priority if (start) begin
      busy_nxt = 1'b1;
      hit_nxt  = 1'b0;
      lo_nxt   = '0;
      hi_nxt   = count;
    end else if (busy_r) begin
      priority if (lo_r >= hi_r) begin
        busy_nxt = 1'b0;
        pos_nxt  = lo_r;
      end else if (holds[mid_idx]) begin
        busy_nxt = 1'b0;
        hit_nxt  = 1'b1;
        pos_nxt  = mid;
      end else if (le[mid_idx]) begin
        lo_nxt = mid + CNT_W'(1);
      end else begin
        hi_nxt = mid;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    hit_r <= hit_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    pos_r <= pos_nxt;
  end

  assign busy = busy_r;
  assign hit  = hit_r;
  assign pos  = pos_r;

endmodule

// ----- design/address_range_region_table.sv -----
// Top level: sorted address window table built from a chain of slot cells.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_stall  | cmd, win_id, addr, length
//  out_    | result    | out_valid/out_stall| status, hit, range_free, entry_*, entry_count
//
// Insert, clear, find by id and unknown commands pass through the accept, execute and result steps.
// Remove repeats the execute step once per removed entry; each pass shifts the cell row one slot from the match.
// Address lookups run in the search step, which ends when the one-probe-per-cycle searches are done.
// A result waits in the output register while out_stall is high; the next request is taken then.
// Reset empties the table and drops any pending result.
module address_range_region_table #(
  parameter int MAX_ENTRIES    = 64,
  parameter int MAX_WINDOW_IDS = 1024,
  parameter int ADDR_BITS      = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [arrt_pkg::CMD_W-1:0]       in_cmd,
  input  logic [arrt_pkg::ID_W-1:0]        in_win_id,
  input  logic [ADDR_BITS-1:0]             in_addr,
  input  logic [ADDR_BITS-1:0]             in_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [arrt_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_hit,
  output logic                             out_range_free,
  output logic [arrt_pkg::ID_W-1:0]        out_entry_id,
  output logic [ADDR_BITS-1:0]             out_entry_base,
  output logic [ADDR_BITS-1:0]             out_entry_length,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] out_entry_count
);
  import arrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [ADDR_BITS-1:0] ONE = {{(ADDR_BITS-1){1'b0}}, 1'b1};

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [ADDR_BITS-1:0] key_a_r, key_a_nxt;
  logic [ADDR_BITS-1:0] key_e_r, key_e_nxt;
  logic [ADDR_BITS-1:0] len_r, len_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;

  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 res_free_r, res_free_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic [ADDR_BITS-1:0] res_base_r, res_base_nxt;
  logic [ADDR_BITS-1:0] res_len_r, res_len_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_free_r, out_free_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [ADDR_BITS-1:0] out_base_r, out_base_nxt;
  logic [ADDR_BITS-1:0] out_len_r, out_len_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  cell_ctl_t            ctl;
  logic                 search_start;
  logic                 bad_id, full, any_match, searches_done, range_match;

  logic [ID_W-1:0]      c_id [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] c_base [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] c_len [MAX_ENTRIES];
  logic [ID_W-1:0]      l_id [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] l_base [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] l_len [MAX_ENTRIES];
  logic [ID_W-1:0]      r_id [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] r_base [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] r_len [MAX_ENTRIES];
  logic [ID_W-1:0]      p_id [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] p_base [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] p_len [MAX_ENTRIES];
  logic                 stay [MAX_ENTRIES+1];
  logic                 seen [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] f_holds_a, f_le_a, f_holds_e, f_le_e;

  logic [ID_W-1:0]      bus_id;
  logic [ADDR_BITS-1:0] bus_base;
  logic [ADDR_BITS-1:0] bus_len;

  logic                 busy_a, hit_a, busy_e, hit_e;
  logic [CNT_W-1:0]     pos_a, pos_e;

  assign stay[0] = 1'b1;
  assign seen[0] = 1'b0;
  assign any_match = seen[MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign l_id[i]   = '0;
      assign l_base[i] = '0;
      assign l_len[i]  = '0;
    end else begin : g_mid_l
      assign l_id[i]   = c_id[i-1];
      assign l_base[i] = c_base[i-1];
      assign l_len[i]  = c_len[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign r_id[i]   = '0;
      assign r_base[i] = '0;
      assign r_len[i]  = '0;
    end else begin : g_mid_r
      assign r_id[i]   = c_id[i+1];
      assign r_base[i] = c_base[i+1];
      assign r_len[i]  = c_len[i+1];
    end

    arrt_cell #(
      .ADDR_BITS (ADDR_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (used_r),
      .pos        (pos_a),
      .key_id     (id_r),
      .key_a      (key_a_r),
      .key_e      (key_e_r),
      .key_len    (len_r),
      .left_stay  (stay[i]),
      .left_id    (l_id[i]),
      .left_base  (l_base[i]),
      .left_len   (l_len[i]),
      .right_id   (r_id[i]),
      .right_base (r_base[i]),
      .right_len  (r_len[i]),
      .seen_in    (seen[i]),
      .stay       (stay[i+1]),
      .seen_out   (seen[i+1]),
      .id         (c_id[i]),
      .base       (c_base[i]),
      .len        (c_len[i]),
      .holds_a    (f_holds_a[i]),
      .le_a       (f_le_a[i]),
      .holds_e    (f_holds_e[i]),
      .le_e       (f_le_e[i]),
      .pick_id    (p_id[i]),
      .pick_base  (p_base[i]),
      .pick_len   (p_len[i])
    );
  end

  always_comb begin
    bus_id   = '0;
    bus_base = '0;
    bus_len  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      bus_id   = bus_id | p_id[i];
      bus_base = bus_base | p_base[i];
      bus_len  = bus_len | p_len[i];
    end
  end

  arrt_search #(
    .N     (MAX_ENTRIES),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_search_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (search_start),
    .count (used_r),
    .holds (f_holds_a),
    .le    (f_le_a),
    .busy  (busy_a),
    .hit   (hit_a),
    .pos   (pos_a)
  );

  arrt_search #(
    .N     (MAX_ENTRIES),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_search_e (
    .clk   (clk),
    .rst_n (rst_n),
    .start (search_start),
    .count (used_r),
    .holds (f_holds_e),
    .le    (f_le_e),
    .busy  (busy_e),
    .hit   (hit_e),
    .pos   (pos_e)
  );

  assign bad_id        = (id_r == '0) || (32'(id_r) >= 32'(MAX_WINDOW_IDS));
  assign full          = used_r == CNT_W'(MAX_ENTRIES);
  assign searches_done = !busy_a && !busy_e;
  assign range_match   = hit_a && hit_e && (pos_a == pos_e);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_REMOVE:     state_nxt = any_match ? ST_EXEC : ST_FIN;
          CMD_FIND_ADDR,
          CMD_CHECK_FREE,
          CMD_FIND_RANGE: state_nxt = ST_SEARCH;
          default:        state_nxt = ST_FIN;
        endcase
      end
      ST_SEARCH: begin
        if (searches_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    ctl            = '{op: CELL_HOLD, pick: PICK_NONE};
    search_start   = 1'b0;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    key_a_nxt      = key_a_r;
    key_e_nxt      = key_e_r;
    len_nxt        = len_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_free_nxt   = res_free_r;
    res_id_nxt     = res_id_r;
    res_base_nxt   = res_base_r;
    res_len_nxt    = res_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_free_nxt   = out_free_r;
    out_id_nxt     = out_id_r;
    out_base_nxt   = out_base_r;
    out_len_nxt    = out_len_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          id_nxt         = in_win_id;
          key_a_nxt      = in_addr;
          key_e_nxt      = in_addr + in_length - ONE;
          len_nxt        = in_length;
          res_status_nxt = STATUS_OK;
          res_hit_nxt    = 1'b0;
          res_free_nxt   = 1'b0;
          res_id_nxt     = '0;
          res_base_nxt   = '0;
          res_len_nxt    = '0;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            priority if (bad_id) begin
              res_status_nxt = STATUS_BAD_ID;
            end else if (full) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              ctl.op   = CELL_INSERT;
              used_nxt = used_r + CNT_W'(1);
            end
          end
          CMD_REMOVE: begin
            if (any_match) begin
              ctl.op      = CELL_REMOVE;
              used_nxt    = used_r - CNT_W'(1);
              res_hit_nxt = 1'b1;
            end
          end
          CMD_CLEAR: begin
            used_nxt = '0;
          end
          CMD_FIND_ID: begin
            ctl.pick     = PICK_FIRST_ID;
            res_hit_nxt  = any_match;
            res_id_nxt   = bus_id;
            res_base_nxt = bus_base;
            res_len_nxt  = bus_len;
          end
          CMD_FIND_ADDR,
          CMD_CHECK_FREE,
          CMD_FIND_RANGE: begin
            search_start = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_SEARCH: begin
        if (searches_done) begin
          unique case (cmd_r)
            CMD_FIND_ADDR: begin
              res_hit_nxt = hit_a;
              if (hit_a) ctl.pick = PICK_POS;
            end
            CMD_CHECK_FREE: begin
              res_free_nxt = !hit_a && !hit_e && (pos_a == pos_e);
            end
            CMD_FIND_RANGE: begin
              res_hit_nxt = range_match;
              if (range_match) ctl.pick = PICK_POS;
            end
            default: begin
            end
          endcase
          res_id_nxt   = bus_id;
          res_base_nxt = bus_base;
          res_len_nxt  = bus_len;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = res_hit_r;
          out_free_nxt   = res_free_r;
          out_id_nxt     = res_id_r;
          out_base_nxt   = res_base_r;
          out_len_nxt    = res_len_r;
          out_count_nxt  = used_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    key_a_r      <= key_a_nxt;
    key_e_r      <= key_e_nxt;
    len_r        <= len_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_free_r   <= res_free_nxt;
    res_id_r     <= res_id_nxt;
    res_base_r   <= res_base_nxt;
    res_len_r    <= res_len_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_free_r   <= out_free_nxt;
    out_id_r     <= out_id_nxt;
    out_base_r   <= out_base_nxt;
    out_len_r    <= out_len_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit          = out_hit_r;
  assign out_range_free   = out_free_r;
  assign out_entry_id     = out_id_r;
  assign out_entry_base   = out_base_r;
  assign out_entry_length = out_len_r;
  assign out_entry_count  = out_count_r;

endmodule
